FILE: rtl/core/tsh_pkg.sv
// ----------------------------------------------------------------------------
// tsh_pkg
// Shared types and constants for the thermistor Steinhart-Hart converter.
// ----------------------------------------------------------------------------
package tsh_pkg;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_FULL = 2'd2,
        ST_SAT  = 2'd3
    } status_t;

    localparam int SAMPLE_W    = 10;
    localparam int TEMP_W      = 16;
    localparam int RS_W        = 24;
    localparam int COEF_W      = 48;
    localparam int CFG_ADDR_W  = 8;
    localparam int X_W         = 24;   // log operand width
    localparam int FRAC_LN     = 28;   // fraction bits of log values
    localparam int LN_W        = 33;   // unsigned ln in Q.28
    localparam int L_W         = 36;   // signed ln R
    localparam int L2_W        = 40;   // signed ln^2 R
    localparam int L3_W        = 45;   // signed ln^3 R
    localparam int BL_W        = 54;   // signed B*ln R
    localparam int D_W         = 64;   // signed denominator, Q.48
    localparam int RECIP_SHIFT = 52;   // 16 / D in Q.48 -> numerator 2^52

    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [TEMP_W-1:0] TEMP_MAX = '1;

    localparam logic [CFG_ADDR_W-1:0] REG_RS     = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_A = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_B = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_C = 8'd3;

    localparam logic [RS_W-1:0]          RS_RESET     = 24'd100;
    localparam logic signed [COEF_W-1:0] COEF_A_RESET = 48'sd394064967395;
    localparam logic signed [COEF_W-1:0] COEF_B_RESET = 48'sd66709569480;
    localparam logic signed [COEF_W-1:0] COEF_C_RESET = 48'sd27866023;

endpackage

FILE: rtl/core/tsh_ln3.sv
// ----------------------------------------------------------------------------
// tsh_ln3
// Three-lane pipelined natural log; outputs ln(x0) + ln(x1) - ln(x2) in Q.28.
// ----------------------------------------------------------------------------
module tsh_ln3 (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  tsh_pkg::status_t                     in_status,
    input  logic [2:0][tsh_pkg::X_W-1:0]         in_x,
    output logic                                 out_valid,
    output tsh_pkg::status_t                     out_status,
    output logic signed [tsh_pkg::L_W-1:0]       out_l
);

    localparam int NST = tsh_pkg::FRAC_LN;

    logic [2:0][31:0]      m_reg  [NST+1];
    logic [2:0][31:0]      m_next [NST+1];
    logic [2:0][4:0]       k_reg  [NST+1];
    logic [2:0][4:0]       k_next [NST+1];
    logic [2:0][NST-1:0]   f_reg  [NST+1];
    logic [2:0][NST-1:0]   f_next [NST+1];
    logic [2:0][63:0]      sq     [NST];
    logic [NST:0]          v_reg;
    tsh_pkg::status_t      s_reg  [NST+1];

    logic [2:0][62:0]               prod;
    logic [2:0][tsh_pkg::LN_W-1:0]  ln_next, ln_reg;
    logic                           ln_v_reg;
    tsh_pkg::status_t               ln_s_reg;
    logic signed [tsh_pkg::L_W-1:0] l_next, l_reg;
    logic                           l_v_reg;
    tsh_pkg::status_t               l_s_reg;

    always_comb begin
        for (int n = 0; n < 3; n++) begin
            // normalize: top set bit to bit 31
            k_next[0][n] = '0;
            for (int b = 0; b < tsh_pkg::X_W; b++) begin
                if (in_x[n][b]) begin
                    k_next[0][n] = 5'(b);
                end
            end
            m_next[0][n] = 32'(in_x[n]) << (5'd31 - k_next[0][n]);
            f_next[0][n] = '0;
        end
        // one log2 fraction bit per stage by squaring
        for (int j = 1; j <= NST; j++) begin
            for (int n = 0; n < 3; n++) begin
                sq[j-1][n] = {32'b0, m_reg[j-1][n]} * {32'b0, m_reg[j-1][n]};
                if (sq[j-1][n][63]) begin
                    m_next[j][n] = sq[j-1][n][63:32];
                end else begin
                    m_next[j][n] = sq[j-1][n][62:31];
                end
                f_next[j][n] = {f_reg[j-1][n][NST-2:0], sq[j-1][n][63]};
                k_next[j][n] = k_reg[j-1][n];
            end
        end
        for (int n = 0; n < 3; n++) begin
            prod[n]    = {30'b0, k_reg[NST][n], f_reg[NST][n]} * {33'b0, tsh_pkg::LN2_Q30};
            ln_next[n] = prod[n][62:30];
        end
        l_next = $signed({3'b0, ln_reg[0]}) + $signed({3'b0, ln_reg[1]})
               - $signed({3'b0, ln_reg[2]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg    <= '0;
            ln_v_reg <= 1'b0;
            l_v_reg  <= 1'b0;
        end else if (en) begin
            v_reg    <= {v_reg[NST-1:0], in_valid};
            ln_v_reg <= v_reg[NST];
            l_v_reg  <= ln_v_reg;
            s_reg[0] <= in_status;
            for (int j = 0; j <= NST; j++) begin
                m_reg[j] <= m_next[j];
                k_reg[j] <= k_next[j];
                f_reg[j] <= f_next[j];
                if (j > 0) begin
                    s_reg[j] <= s_reg[j-1];
                end
            end
            ln_reg   <= ln_next;
            ln_s_reg <= s_reg[NST];
            l_reg    <= l_next;
            l_s_reg  <= ln_s_reg;
        end
    end

    assign out_valid  = l_v_reg;
    assign out_status = l_s_reg;
    assign out_l      = l_reg;

endmodule

FILE: rtl/core/tsh_mulsh.sv
// ----------------------------------------------------------------------------
// tsh_mulsh
// Pipelined signed multiply, product / 2^28 truncated toward zero.
// ----------------------------------------------------------------------------
module tsh_mulsh #(
    parameter int AW = 36,
    parameter int BW = 36,
    parameter int OW = 40,
    parameter int TW = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [AW-1:0]  in_a,
    input  logic signed [BW-1:0]  in_b,
    input  logic [TW-1:0]         in_tag,
    output logic                  out_valid,
    output logic signed [OW-1:0]  out_p,
    output logic [TW-1:0]         out_tag
);

    localparam int MW   = (AW > BW) ? AW : BW;
    localparam int HW   = (MW + 1) / 2;
    localparam int PW   = 2 * HW;
    localparam int MIDW = PW + 1;
    localparam int FW   = 4 * HW;
    localparam int NS   = 5;

    logic [NS-1:0]          v_reg;
    logic [TW-1:0]          tag_reg [NS];
    logic [NS-2:0]          neg_reg;
    logic [AW-1:0]          a_abs;
    logic [BW-1:0]          b_abs;
    logic [PW-1:0]          ma_reg, mb_reg;
    logic [PW-1:0]          p00_reg, p01_reg, p10_reg, p11_reg;
    logic [PW-1:0]          q00_reg, q11_reg;
    logic [MIDW-1:0]        mid_reg;
    logic [FW-1:0]          full;
    logic [OW-1:0]          mag_reg;
    logic signed [OW-1:0]   p_next, p_reg;

    always_comb begin
        a_abs  = in_a[AW-1] ? AW'(-in_a) : AW'(in_a);
        b_abs  = in_b[BW-1] ? BW'(-in_b) : BW'(in_b);
        full   = FW'(q00_reg) + (FW'(mid_reg) << HW) + (FW'(q11_reg) << PW);
        p_next = neg_reg[NS-2] ? -$signed(mag_reg) : $signed(mag_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg      <= {v_reg[NS-2:0], in_valid};
            tag_reg[0] <= in_tag;
            for (int i = 1; i < NS; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
            neg_reg <= {neg_reg[NS-3:0], in_a[AW-1] ^ in_b[BW-1]};
            // magnitudes
            ma_reg  <= PW'(a_abs);
            mb_reg  <= PW'(b_abs);
            // partial products
            p00_reg <= PW'(ma_reg[HW-1:0]) * PW'(mb_reg[HW-1:0]);
            p01_reg <= PW'(ma_reg[HW-1:0]) * PW'(mb_reg[PW-1:HW]);
            p10_reg <= PW'(ma_reg[PW-1:HW]) * PW'(mb_reg[HW-1:0]);
            p11_reg <= PW'(ma_reg[PW-1:HW]) * PW'(mb_reg[PW-1:HW]);
            // cross terms
            q00_reg <= p00_reg;
            q11_reg <= p11_reg;
            mid_reg <= MIDW'(p01_reg) + MIDW'(p10_reg);
            // combine and scale
            mag_reg <= OW'(full >> tsh_pkg::FRAC_LN);
            p_reg   <= p_next;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_tag   = tag_reg[NS-1];
    assign out_p     = p_reg;

endmodule

FILE: rtl/core/tsh_recip.sv
// ----------------------------------------------------------------------------
// tsh_recip
// Denominator sum, range checks and 16-stage restoring divide of 2^52 by D.
// ----------------------------------------------------------------------------
module tsh_recip (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  tsh_pkg::status_t                      in_status,
    input  logic signed [tsh_pkg::COEF_W-1:0]     coef_a,
    input  logic signed [tsh_pkg::BL_W-1:0]       in_bl,
    input  logic signed [tsh_pkg::D_W-1:0]        in_cl3,
    output logic                                  out_valid,
    output logic [tsh_pkg::TEMP_W-1:0]            out_temp,
    output tsh_pkg::status_t                      out_status
);

    localparam int QW = tsh_pkg::TEMP_W;
    localparam int DW = tsh_pkg::D_W;
    localparam int RW = DW - 1;
    localparam int SW = RW + QW;

    logic signed [DW-1:0]   d_reg;
    logic                   d_v_reg;
    tsh_pkg::status_t       d_s_reg;

    logic                   d_pos;
    logic [RW-1:0]          num;
    logic                   ovf;
    tsh_pkg::status_t       pre_status;

    logic [RW-1:0]          rem_reg  [QW+1];
    logic [RW-1:0]          rem_next [QW+1];
    logic [RW-1:0]          dv_reg   [QW+1];
    logic [QW-1:0]          q_reg    [QW+1];
    logic [QW-1:0]          q_next   [QW+1];
    logic [SW-1:0]          sh       [QW];
    logic [QW-1:0]          ge;
    logic [QW:0]            v_reg;
    tsh_pkg::status_t       s_reg    [QW+1];

    logic [QW-1:0]          temp_next, temp_reg;
    logic                   o_v_reg;
    tsh_pkg::status_t       o_s_reg;

    always_comb begin
        d_pos = !d_reg[DW-1] && (d_reg != '0);
        num   = (RW'(1) << tsh_pkg::RECIP_SHIFT) + RW'(d_reg[RW-1:0] >> 1);
        ovf   = {QW'(0), num} >= {d_reg[RW-1:0], QW'(0)};
        pre_status = d_s_reg;
        if (d_s_reg == tsh_pkg::ST_OK && (!d_pos || ovf)) begin
            pre_status = tsh_pkg::ST_SAT;
        end
        rem_next[0] = num;
        q_next[0]   = '0;
        for (int j = 1; j <= QW; j++) begin
            sh[j-1] = SW'(dv_reg[j-1]) << (QW - j);
            ge[j-1] = SW'(rem_reg[j-1]) >= sh[j-1];
            if (ge[j-1]) begin
                rem_next[j] = RW'(SW'(rem_reg[j-1]) - sh[j-1]);
            end else begin
                rem_next[j] = rem_reg[j-1];
            end
            q_next[j] = {q_reg[j-1][QW-2:0], ge[j-1]};
        end
        unique case (s_reg[QW])
            tsh_pkg::ST_OK:  temp_next = q_reg[QW];
            tsh_pkg::ST_SAT: temp_next = tsh_pkg::TEMP_MAX;
            default:         temp_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_v_reg <= 1'b0;
            v_reg   <= '0;
            o_v_reg <= 1'b0;
        end else if (en) begin
            d_v_reg  <= in_valid;
            d_reg    <= DW'(coef_a) + DW'(in_bl) + in_cl3;
            d_s_reg  <= in_status;
            v_reg    <= {v_reg[QW-1:0], d_v_reg};
            s_reg[0] <= pre_status;
            dv_reg[0] <= d_reg[RW-1:0];
            for (int j = 0; j <= QW; j++) begin
                rem_reg[j] <= rem_next[j];
                q_reg[j]   <= q_next[j];
                if (j > 0) begin
                    dv_reg[j] <= dv_reg[j-1];
                    s_reg[j]  <= s_reg[j-1];
                end
            end
            o_v_reg  <= v_reg[QW];
            o_s_reg  <= s_reg[QW];
            temp_reg <= temp_next;
        end
    end

    assign out_valid  = o_v_reg;
    assign out_temp   = temp_reg;
    assign out_status = o_s_reg;

endmodule

FILE: rtl/core/thermistor_steinhart_hart_top.sv
// ----------------------------------------------------------------------------
// thermistor_steinhart_hart_top
// Converts a thermistor divider ADC count to kelvin (Q4) via Steinhart-Hart.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the output buffer is not full;
//   the 28-stage log lanes, four 5-stage multipliers and the 16-stage
//   divider are fully pipelined.
// A 2-entry output buffer absorbs back-pressure; s_tready drops only when
//   both entries hold results, and then the whole pipeline holds.
// Reset (aresetn low, synchronous): clears all valid bits and the output
//   buffer, and loads the register reset values (Rs = 100 ohm, A, B, C).
// ----------------------------------------------------------------------------
module thermistor_steinhart_hart_top #(
    parameter int ADC_BITS = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write port
    input  logic                                cfg_we,
    input  logic [tsh_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [tsh_pkg::COEF_W-1:0]          cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // [9:0] adc_sample
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata    // [15:0] temperature_q4,
                                                           // [17:16] status
);

    localparam int CMP_W = (ADC_BITS > tsh_pkg::SAMPLE_W) ? ADC_BITS : tsh_pkg::SAMPLE_W;
    localparam logic [CMP_W-1:0] FS = CMP_W'((1 << ADC_BITS) - 1);
    localparam int RES_W  = tsh_pkg::TEMP_W + 2;
    localparam int TAG1_W = 2 + tsh_pkg::L_W;
    localparam int TAG3_W = 2 + tsh_pkg::L3_W;
    localparam int TAG4_W = 2 + tsh_pkg::BL_W;

    // ---------------- configuration registers ----------------
    logic [tsh_pkg::RS_W-1:0]          rs_reg;
    logic signed [tsh_pkg::COEF_W-1:0] coef_a_reg, coef_b_reg, coef_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rs_reg     <= tsh_pkg::RS_RESET;
            coef_a_reg <= tsh_pkg::COEF_A_RESET;
            coef_b_reg <= tsh_pkg::COEF_B_RESET;
            coef_c_reg <= tsh_pkg::COEF_C_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                tsh_pkg::REG_RS:     rs_reg     <= cfg_wdata[tsh_pkg::RS_W-1:0];
                tsh_pkg::REG_COEF_A: coef_a_reg <= $signed(cfg_wdata);
                tsh_pkg::REG_COEF_B: coef_b_reg <= $signed(cfg_wdata);
                tsh_pkg::REG_COEF_C: coef_c_reg <= $signed(cfg_wdata);
                default: ;   // unmapped index: ignored
            endcase
        end
    end

    // ---------------- pipeline enable ----------------
    // Advance whenever the output buffer is not full. Registered count only,
    // so m_tready never reaches s_tready combinationally.
    logic [1:0] ocnt_reg, ocnt_next;
    logic       en;

    assign en       = (ocnt_reg != 2'd2);
    assign s_tready = en;

    // ---------------- input stage: classify the count ----------------
    logic [tsh_pkg::SAMPLE_W-1:0]      sample;
    logic [CMP_W-1:0]                  cnt_ext;
    logic [tsh_pkg::RS_W-1:0]          rs_eff;
    tsh_pkg::status_t                  in_status_next, in_status_reg;
    logic [2:0][tsh_pkg::X_W-1:0]      x_next, x_reg;
    logic                              in_v_reg;

    always_comb begin
        sample  = s_tdata[tsh_pkg::SAMPLE_W-1:0];
        cnt_ext = CMP_W'(sample);
        // a zero series resistance reads as 1 ohm
        rs_eff  = (rs_reg == '0) ? tsh_pkg::RS_W'(1) : rs_reg;
        priority if (sample == '0) begin
            in_status_next = tsh_pkg::ST_ZERO;
        end else if (cnt_ext >= FS) begin
            in_status_next = tsh_pkg::ST_FULL;
        end else begin
            in_status_next = tsh_pkg::ST_OK;
        end
        // log operands: ln R = ln Rs + ln(FS - count) - ln count
        if (in_status_next == tsh_pkg::ST_OK) begin
            x_next[0] = rs_eff;
            x_next[1] = tsh_pkg::X_W'(FS - cnt_ext);
            x_next[2] = tsh_pkg::X_W'(sample);
        end else begin
            // result fixed by status; keep log lanes on a legal operand
            x_next[0] = tsh_pkg::X_W'(1);
            x_next[1] = tsh_pkg::X_W'(1);
            x_next[2] = tsh_pkg::X_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (en) begin
            in_v_reg      <= s_tvalid;
            in_status_reg <= in_status_next;
            x_reg         <= x_next;
        end
    end

    // ---------------- ln R ----------------
    logic                              l_valid;
    tsh_pkg::status_t                  l_status;
    logic signed [tsh_pkg::L_W-1:0]    l_val;

    tsh_ln3 u_ln3 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (in_v_reg),
        .in_status  (in_status_reg),
        .in_x       (x_reg),
        .out_valid  (l_valid),
        .out_status (l_status),
        .out_l      (l_val)
    );

    // ---------------- L2 = L*L ----------------
    logic                              m1_valid;
    logic signed [tsh_pkg::L2_W-1:0]   l2_val;
    logic [TAG1_W-1:0]                 m1_tag;

    tsh_mulsh #(
        .AW (tsh_pkg::L_W),
        .BW (tsh_pkg::L_W),
        .OW (tsh_pkg::L2_W),
        .TW (TAG1_W)
    ) u_mul_l2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (l_valid),
        .in_a      (l_val),
        .in_b      (l_val),
        .in_tag    ({l_status, l_val}),
        .out_valid (m1_valid),
        .out_p     (l2_val),
        .out_tag   (m1_tag)
    );

    // ---------------- L3 = L2*L ----------------
    logic                              m2_valid;
    logic signed [tsh_pkg::L3_W-1:0]   l3_val;
    logic [TAG1_W-1:0]                 m2_tag;

    tsh_mulsh #(
        .AW (tsh_pkg::L2_W),
        .BW (tsh_pkg::L_W),
        .OW (tsh_pkg::L3_W),
        .TW (TAG1_W)
    ) u_mul_l3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m1_valid),
        .in_a      (l2_val),
        .in_b      ($signed(m1_tag[tsh_pkg::L_W-1:0])),
        .in_tag    (m1_tag),
        .out_valid (m2_valid),
        .out_p     (l3_val),
        .out_tag   (m2_tag)
    );

    // ---------------- B*L ----------------
    logic                              m3_valid;
    logic signed [tsh_pkg::BL_W-1:0]   bl_val;
    logic [TAG3_W-1:0]                 m3_tag;

    tsh_mulsh #(
        .AW (tsh_pkg::COEF_W),
        .BW (tsh_pkg::L_W),
        .OW (tsh_pkg::BL_W),
        .TW (TAG3_W)
    ) u_mul_bl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m2_valid),
        .in_a      (coef_b_reg),
        .in_b      ($signed(m2_tag[tsh_pkg::L_W-1:0])),
        .in_tag    ({m2_tag[TAG1_W-1 -: 2], l3_val}),
        .out_valid (m3_valid),
        .out_p     (bl_val),
        .out_tag   (m3_tag)
    );

    // ---------------- C*L3 ----------------
    logic                              m4_valid;
    logic signed [tsh_pkg::D_W-1:0]    cl3_val;
    logic [TAG4_W-1:0]                 m4_tag;

    tsh_mulsh #(
        .AW (tsh_pkg::COEF_W),
        .BW (tsh_pkg::L3_W),
        .OW (tsh_pkg::D_W),
        .TW (TAG4_W)
    ) u_mul_cl3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m3_valid),
        .in_a      (coef_c_reg),
        .in_b      ($signed(m3_tag[tsh_pkg::L3_W-1:0])),
        .in_tag    ({m3_tag[TAG3_W-1 -: 2], bl_val}),
        .out_valid (m4_valid),
        .out_p     (cl3_val),
        .out_tag   (m4_tag)
    );

    // ---------------- D = A + BL + CL3, T = 16 / D ----------------
    logic                              rc_valid;
    logic [tsh_pkg::TEMP_W-1:0]        rc_temp;
    tsh_pkg::status_t                  rc_status;

    tsh_recip u_recip (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (m4_valid),
        .in_status  (tsh_pkg::status_t'(m4_tag[TAG4_W-1 -: 2])),
        .coef_a     (coef_a_reg),
        .in_bl      ($signed(m4_tag[tsh_pkg::BL_W-1:0])),
        .in_cl3     (cl3_val),
        .out_valid  (rc_valid),
        .out_temp   (rc_temp),
        .out_status (rc_status)
    );

    // ---------------- 2-entry output buffer ----------------
    logic [RES_W-1:0] res;
    logic [RES_W-1:0] head_reg, head_next, tail_reg, tail_next;
    logic             push, pop;

    always_comb begin
        res       = {rc_status, rc_temp};
        push      = en && rc_valid;
        pop       = (ocnt_reg != 2'd0) && m_tready;
        head_next = head_reg;
        tail_next = tail_reg;
        ocnt_next = ocnt_reg;
        unique case (ocnt_reg)
            2'd0: begin
                if (push) begin
                    head_next = res;
                    ocnt_next = 2'd1;
                end
            end
            2'd1: begin
                priority if (push && pop) begin
                    head_next = res;
                end else if (push) begin
                    tail_next = res;
                    ocnt_next = 2'd2;
                end else if (pop) begin
                    ocnt_next = 2'd0;
                end
            end
            2'd2: begin
                if (pop) begin
                    head_next = tail_reg;
                    ocnt_next = 2'd1;
                end
            end
            default: ocnt_next = 2'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ocnt_reg <= 2'd0;
        end else begin
            ocnt_reg <= ocnt_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    assign m_tvalid = (ocnt_reg != 2'd0);
    assign m_tdata  = {6'b0, head_reg};

endmodule

FILE: rtl/core/tsh_checker.sv
// ----------------------------------------------------------------------------
// tsh_checker
// Port-level assertions for the thermistor converter, bound to the top.
// ----------------------------------------------------------------------------
module tsh_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // reset empties the output
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid after reset");

    // input only backs off when a result is waiting
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no result pending");

    // zero / full-scale counts give zero temperature
    a_edge_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[17:16] == tsh_pkg::ST_ZERO
                  || m_tdata[17:16] == tsh_pkg::ST_FULL) |-> m_tdata[15:0] == 16'h0)
        else $error("nonzero temperature on zero/full-scale status");

    // saturation gives full-scale temperature
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17:16] == tsh_pkg::ST_SAT |-> m_tdata[15:0] == 16'hFFFF)
        else $error("saturated status without max temperature");

endmodule

bind thermistor_steinhart_hart_top tsh_checker u_tsh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
